/* rtl/assert_macros.svh */
// assertion macros used by the rtl top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge, off while reset is held
`define SCL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("scl assertion failed");

// plain check on every edge, reset included
`define SCL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) else $error("scl assertion failed");

`endif

/* rtl/scl_pkg.sv */
// types, coefficient tables and helpers of the stereo crossover / lfe split
// no dependencies
`default_nettype none

package scl_pkg;

    localparam int unsigned COEF_W = 64;
    localparam int unsigned HIST_W = 48;
    localparam int unsigned ACC_W  = 56;
    localparam int unsigned PROD_W = 112;
    localparam int unsigned SMP_W  = 16;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [HIST_W-1:0] t_hist;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SMP_W-1:0]  t_smp;

    // request to and response from the shared multiplier
    typedef struct packed {
        logic  start;
        t_coef a;
        t_hist b;
    } t_mul_req;

    typedef struct packed {
        logic  done;
        t_prod prod;
    } t_mul_rsp;

    // decimal mantissa * 10^-exp10 to q4.59, rounded half up in magnitude
    function automatic t_coef f_q59(logic [63:0] mant, int unsigned exp10, bit neg);
        logic [127:0] w;
        logic [63:0]  m;
        w = {mant, 64'd0} >> 4;
        for (int unsigned e = 0; e < exp10; e++) begin
            w = w / 128'd10;
        end
        w = (w + 128'd1) >> 1;
        m = {1'b0, w[62:0]};
        return neg ? t_coef'(-$signed(m)) : t_coef'($signed(m));
    endfunction

    localparam t_coef LP_NUM [8] = '{
        f_q59(64'd5902287323061, 24, 1'b0), f_q59(64'd2951143661531, 23, 1'b0),
        f_q59(64'd5902287323061, 23, 1'b0), f_q59(64'd5902287323061, 23, 1'b0),
        f_q59(64'd2951143661531, 23, 1'b0), f_q59(64'd5902287323061, 24, 1'b0),
        64'sd0, 64'sd0};

    localparam t_coef HP_NUM [8] = '{
        f_q59(64'd981726438035, 12, 1'b0), f_q59(64'd4908632190175, 12, 1'b1),
        f_q59(64'd981726438035, 11, 1'b0), f_q59(64'd981726438035, 11, 1'b1),
        f_q59(64'd4908632190175, 12, 1'b0), f_q59(64'd981726438035, 12, 1'b1),
        64'sd0, 64'sd0};

    localparam t_coef DEN [8] = '{
        f_q59(64'd1, 0, 1'b0), f_q59(64'd4963115133507, 12, 1'b1),
        f_q59(64'd9853139865557, 12, 1'b0), f_q59(64'd9780721075822, 12, 1'b1),
        f_q59(64'd4854483143098, 12, 1'b0), f_q59(64'd963786799137, 12, 1'b1),
        64'sd0, 64'sd0};

    localparam t_acc Y_MAX = t_acc'(48'sh7FFF_FFFF_FFFF);
    localparam t_acc Y_MIN = t_acc'(-48'sh7FFF_FFFF_FFFF - 48'sd1);

    function automatic t_smp f_sat16(t_acc v);
        if (v > t_acc'(32767)) begin
            return t_smp'(32767);
        end else if (v < t_acc'(-32767)) begin
            return t_smp'(-32767);
        end
        return t_smp'(v);
    endfunction

endpackage

`default_nettype wire

/* rtl/scl_if.sv */
// stream and configuration channel interfaces of the crossover block
// depends on scl_pkg
`default_nettype none

interface scl_in_if;
    logic             valid;
    logic             ready;
    scl_pkg::t_smp    left_in;
    scl_pkg::t_smp    right_in;
    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface scl_out_if;
    logic             valid;
    logic             ready;
    scl_pkg::t_smp    surround_left;
    scl_pkg::t_smp    surround_right;
    scl_pkg::t_smp    lfe_out;
    modport source (output valid, output surround_left, output surround_right,
                    output lfe_out, input ready);
    modport sink   (input valid, input surround_left, input surround_right,
                    input lfe_out, output ready);
endinterface

interface scl_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/scl_mul.sv */
// shared signed 64 x 48 multiplier, one 33 x 25 partial product per cycle
// depends on scl_pkg
`default_nettype none

module scl_mul (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  scl_pkg::t_mul_req  i_req,
    output scl_pkg::t_mul_rsp  o_rsp
);

    scl_pkg::t_coef      r_a;
    scl_pkg::t_hist      r_b;
    logic [2:0]          r_part;
    logic                r_busy;
    logic signed [57:0]  r_pp;
    logic [1:0]          r_sh;
    logic                r_ppv;
    scl_pkg::t_prod      r_prod;
    logic                r_done;

    logic signed [32:0]  w_ae;
    logic signed [24:0]  w_be;
    logic signed [57:0]  w_mul;
    logic [6:0]          w_amt;
    scl_pkg::t_prod      w_pp_ext;

    // high halves signed, low halves zero extended
    assign w_ae  = r_part[1] ? {r_a[63], r_a[63:32]} : {1'b0, r_a[31:0]};
    assign w_be  = r_part[0] ? {r_b[47], r_b[47:24]} : {1'b0, r_b[23:0]};
    assign w_mul = 58'(w_ae) * 58'(w_be);
    assign w_amt = (r_sh[1] ? 7'd32 : 7'd0) + (r_sh[0] ? 7'd24 : 7'd0);
    assign w_pp_ext = scl_pkg::t_prod'(r_pp) <<< w_amt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ppv  <= 1'b0;
            r_done <= 1'b0;
            r_part <= 3'd0;
        end else if (i_req.start) begin
            r_a    <= i_req.a;
            r_b    <= i_req.b;
            r_part <= 3'd0;
            r_busy <= 1'b1;
            r_ppv  <= 1'b0;
            r_done <= 1'b0;
            r_prod <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_ppv) begin
                r_prod <= r_prod + w_pp_ext;
            end
            if (r_busy) begin
                if (r_part != 3'd4) begin
                    r_pp   <= w_mul;
                    r_sh   <= r_part[1:0];
                    r_ppv  <= 1'b1;
                    r_part <= r_part + 3'd1;
                end else begin
                    r_ppv  <= 1'b0;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_prod;

endmodule

`default_nettype wire

/* rtl/stereo_crossover_lfe_split.sv */
// top level: sequencer, filter histories and output register of the crossover
// depends on scl_pkg, scl_if, scl_mul and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

// Stereo bass-management crossover. Each input item is one left/right pcm
// pair; it runs through a fifth-order lowpass and highpass on each channel
// (direct form i, q4.59 coefficients, 48-bit q23.24 output history) and
// gives one result item: surround left/right from the highpass outputs and
// lfe from the mean of the lowpass outputs times lfe_gain (q4.12). One
// shared 64 x 48 multiplier does every product, one 33 x 25 partial product
// per cycle; each product is issued and then waited for. An item passes
// through the products, one store per filter, the lfe product, the output
// state, which waits until the output register is free, and the accepting
// idle state. Input ready is high only in the idle state. A finished result
// sits in the output register while the next item is taken in.
module stereo_crossover_lfe_split #(
    parameter int FILTER_TAPS = 6
) (
    input  wire i_clk,
    input  wire i_rst_n,
    scl_in_if.sink    i_in,
    scl_cfg_if.sink   i_cfg,
    scl_out_if.source o_out
);

    localparam int HIST = FILTER_TAPS - 1;
    localparam int HW   = (HIST > 1) ? $clog2(HIST) : 1;
    localparam int TW   = $clog2(2 * FILTER_TAPS - 1);
    localparam logic [TW-1:0] LAST_TERM = TW'(2 * FILTER_TAPS - 2);

    typedef enum logic [2:0] {
        S_IDLE, S_ISSUE, S_WAIT, S_STORE, S_LFE_ISSUE, S_LFE_WAIT, S_OUT
    } t_state;

    t_state             r_state;
    logic [1:0]         r_filt;     // ll, rl, lh, rh
    logic [TW-1:0]      r_term;     // numerator taps, then denominator taps
    scl_pkg::t_acc      r_acc;
    scl_pkg::t_acc      r_lfe;
    scl_pkg::t_smp      r_xl;
    scl_pkg::t_smp      r_xr;
    scl_pkg::t_smp      r_xh [2][HIST];
    scl_pkg::t_hist     r_yh [4][HIST];
    logic [15:0]        r_gain;
    logic               r_ovalid;
    scl_pkg::t_smp      r_sl;
    scl_pkg::t_smp      r_sr;
    scl_pkg::t_smp      r_lo;

    scl_pkg::t_mul_req  w_req;
    scl_pkg::t_mul_rsp  w_rsp;

    logic               w_is_den;
    logic [2:0]         w_k;
    logic [HW-1:0]      w_hidx;
    logic               w_ch;
    scl_pkg::t_smp      w_x;
    scl_pkg::t_coef     w_coef;
    scl_pkg::t_hist     w_b;
    scl_pkg::t_acc      w_term;
    scl_pkg::t_acc      w_sum;
    scl_pkg::t_hist     w_ysat;
    logic signed [48:0] w_lfe_sum;
    scl_pkg::t_acc      w_sl_r;
    scl_pkg::t_acc      w_sr_r;
    logic               w_oslot;

    // term decode
    assign w_is_den = (r_term >= TW'(FILTER_TAPS));
    assign w_k      = w_is_den ? 3'(r_term - TW'(FILTER_TAPS - 1)) : 3'(r_term);
    assign w_hidx   = HW'(w_k - 3'd1);
    assign w_ch     = r_filt[0];

    // operand selection for the shared multiplier
    always_comb begin
        if (w_k == 3'd0) begin
            w_x = w_ch ? r_xr : r_xl;
        end else begin
            w_x = r_xh[w_ch][w_hidx];
        end
        if (w_is_den) begin
            w_coef = scl_pkg::DEN[w_k];
            w_b    = r_yh[r_filt][w_hidx];
        end else begin
            w_coef = r_filt[1] ? scl_pkg::HP_NUM[w_k] : scl_pkg::LP_NUM[w_k];
            w_b    = scl_pkg::t_hist'(w_x);
        end
    end

    assign w_lfe_sum = 49'(r_yh[0][0]) + 49'(r_yh[1][0]);

    always_comb begin
        w_req.start = (r_state == S_ISSUE) || (r_state == S_LFE_ISSUE);
        if (r_state == S_LFE_ISSUE) begin
            w_req.a = scl_pkg::t_coef'(w_lfe_sum);
            w_req.b = scl_pkg::t_hist'({1'b0, r_gain});
        end else begin
            w_req.a = w_coef;
            w_req.b = w_b;
        end
    end

    scl_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // each product floored on its own
    assign w_term = w_is_den ? scl_pkg::t_acc'(w_rsp.prod >>> 59)
                             : scl_pkg::t_acc'(w_rsp.prod >>> 35);
    assign w_sum  = w_is_den ? r_acc - w_term : r_acc + w_term;

    // filter output saturated to 48 bits
    always_comb begin
        if (r_acc > scl_pkg::Y_MAX) begin
            w_ysat = scl_pkg::t_hist'(scl_pkg::Y_MAX);
        end else if (r_acc < scl_pkg::Y_MIN) begin
            w_ysat = scl_pkg::t_hist'(scl_pkg::Y_MIN);
        end else begin
            w_ysat = scl_pkg::t_hist'(r_acc);
        end
    end

    // round half up: floor((y + 2^23) / 2^24)
    assign w_sl_r = scl_pkg::t_acc'((49'(r_yh[2][0]) + 49'sd8388608) >>> 24);
    assign w_sr_r = scl_pkg::t_acc'((49'(r_yh[3][0]) + 49'sd8388608) >>> 24);

    assign w_oslot = !r_ovalid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_filt   <= 2'd0;
            r_term   <= '0;
            r_gain   <= 16'd4096;
            r_ovalid <= 1'b0;
            for (int c = 0; c < 2; c++) begin
                for (int h = 0; h < HIST; h++) begin
                    r_xh[c][h] <= '0;
                end
            end
            for (int f = 0; f < 4; f++) begin
                for (int h = 0; h < HIST; h++) begin
                    r_yh[f][h] <= '0;
                end
            end
        end else begin
            if (i_cfg.valid) begin
                r_gain <= i_cfg.data;
            end
            // the output state refills the register on its own
            if (r_ovalid && o_out.ready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_xl    <= i_in.left_in;
                        r_xr    <= i_in.right_in;
                        r_filt  <= 2'd0;
                        r_term  <= '0;
                        r_acc   <= '0;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_rsp.done) begin
                        r_acc <= w_sum;
                        if (r_term == LAST_TERM) begin
                            r_state <= S_STORE;
                        end else begin
                            r_term  <= r_term + TW'(1);
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_STORE: begin
                    for (int h = HIST - 1; h > 0; h--) begin
                        r_yh[r_filt][h] <= r_yh[r_filt][h-1];
                    end
                    r_yh[r_filt][0] <= w_ysat;
                    r_acc  <= '0;
                    r_term <= '0;
                    if (r_filt == 2'd3) begin
                        r_state <= S_LFE_ISSUE;
                    end else begin
                        r_filt  <= r_filt + 2'd1;
                        r_state <= S_ISSUE;
                    end
                end
                S_LFE_ISSUE: begin
                    r_state <= S_LFE_WAIT;
                end
                S_LFE_WAIT: begin
                    if (w_rsp.done) begin
                        // floor((prod / 2^36 + 1) / 2) equals floor((prod + 2^36) / 2^37)
                        r_lfe   <= scl_pkg::t_acc'((w_rsp.prod + 112'sh10_0000_0000) >>> 37);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_oslot) begin
                        r_sl     <= scl_pkg::f_sat16(w_sl_r);
                        r_sr     <= scl_pkg::f_sat16(w_sr_r);
                        r_lo     <= scl_pkg::f_sat16(r_lfe);
                        r_ovalid <= 1'b1;
                        for (int h = HIST - 1; h > 0; h--) begin
                            r_xh[0][h] <= r_xh[0][h-1];
                            r_xh[1][h] <= r_xh[1][h-1];
                        end
                        r_xh[0][0] <= r_xl;
                        r_xh[1][0] <= r_xr;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign i_cfg.ready          = 1'b1;
    assign o_out.valid          = r_ovalid;
    assign o_out.surround_left  = r_sl;
    assign o_out.surround_right = r_sr;
    assign o_out.lfe_out        = r_lo;

    // an accepted item keeps the input closed for the next cycle
    `SCL_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> !i_in.ready)
    // the multiplier only reports back while the sequencer waits for it
    `SCL_ASSERT(a_done_in_wait, i_clk, i_rst_n, w_rsp.done |-> (r_state == S_WAIT || r_state == S_LFE_WAIT))
    // a result appears only out of the output state
    `SCL_ASSERT(a_valid_from_out, i_clk, i_rst_n, $rose(o_out.valid) |-> $past(r_state == S_OUT))
    // term index stays in range while a term is being worked
    `SCL_ASSERT(a_term_range, i_clk, i_rst_n, (r_state == S_WAIT) |-> (r_term <= LAST_TERM))

endmodule

`default_nettype wire

/* tb/tb.sv */
// self-checking testbench of the stereo crossover / lfe split block
// depends on scl_pkg, scl_if and stereo_crossover_lfe_split
`default_nettype none

module tb;

    typedef logic signed [63:0]  t_s64;
    typedef logic signed [127:0] t_s128;

    typedef struct {
        scl_pkg::t_smp left;
        scl_pkg::t_smp right;
    } t_pcm_pair;

    typedef struct {
        scl_pkg::t_smp surround_left;
        scl_pkg::t_smp surround_right;
        scl_pkg::t_smp lfe_out;
    } t_split_out;

    localparam int HOLD_CYCLES = 1500;   // long receiver hold-off
    localparam int WATCHDOG    = 20000;  // cycles with no handshake at all
    localparam int SETTLE      = 400;    // more than one item's latency

    logic clk;
    logic rst_n;

    scl_in_if  in_ch ();
    scl_cfg_if cfg_ch ();
    scl_out_if out_ch ();

    stereo_crossover_lfe_split uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // stimulus waiting to be offered, and results the filters should give
    t_pcm_pair  pcm_backlog[$];
    t_split_out split_due[$];

    int send_idle_pct;
    int recv_stall_pct;
    int fail_count;
    int items_in;
    int items_out;
    int quiet_cycles;
    bit hold_go;
    int hold_count;

    // filter model: q4.59 coefficients, q23.24 output history
    t_s64  lp_coef [6];
    t_s64  hp_coef [6];
    t_s64  den_coef[6];
    t_s64  hist_xl[5], hist_xr[5];
    t_s64  hist_lpl[5], hist_lpr[5], hist_hpl[5], hist_hpr[5];
    logic [15:0] gain_q12;

    // decimal mantissa * 10^-exp10 to q4.59, ties rounded up in magnitude
    function automatic t_s64 dec_to_q59(logic [63:0] mant, int exp10, bit neg);
        logic [127:0] w;
        logic [63:0]  m;
        w = {64'd0, mant} << 60;
        for (int e = 0; e < exp10; e++) begin
            w = w / 128'd10;
        end
        w = (w + 128'd1) >> 1;
        m = {1'b0, w[62:0]};
        return neg ? -$signed(m) : $signed(m);
    endfunction

    // exact product, floored shift, clamped to 64 bits
    function automatic t_s64 mul_floor(t_s128 a, t_s128 b, int sh);
        t_s128 p;
        p = (a * b) >>> sh;
        if (p > t_s128'(64'sh7FFF_FFFF_FFFF_FFFF)) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (p < -t_s128'(64'sh7FFF_FFFF_FFFF_FFFF) - 1) return 64'sh8000_0000_0000_0000;
        return t_s64'(p);
    endfunction

    // one direct-form-i output sample, saturated to 48 bits
    function automatic t_s64 iir_sample(t_s64 num[6], t_s64 x0, t_s64 xh[5], t_s64 yh[5]);
        t_s128 acc;
        acc = mul_floor(num[0], x0, 35);
        for (int k = 1; k < 6; k++) begin
            acc = acc + mul_floor(num[k], xh[k-1], 35) - mul_floor(den_coef[k], yh[k-1], 59);
        end
        if (acc > t_s128'(48'sh7FFF_FFFF_FFFF)) acc = t_s128'(48'sh7FFF_FFFF_FFFF);
        if (acc < -t_s128'(48'sh7FFF_FFFF_FFFF) - 1) acc = -t_s128'(48'sh7FFF_FFFF_FFFF) - 1;
        return t_s64'(acc);
    endfunction

    function automatic scl_pkg::t_smp clamp_pcm(t_s64 v);
        if (v > 32767) return 16'sd32767;
        if (v < -32767) return -16'sd32767;
        return scl_pkg::t_smp'(v);
    endfunction

    // advances the filter state by one pair and gives the expected result
    function automatic t_split_out crossover_step(scl_pkg::t_smp xl_in, scl_pkg::t_smp xr_in);
        t_split_out r;
        t_s64 xl, xr, yll, yrl, ylh, yrh, q;
        xl  = xl_in;
        xr  = xr_in;
        yll = iir_sample(lp_coef, xl, hist_xl, hist_lpl);
        yrl = iir_sample(lp_coef, xr, hist_xr, hist_lpr);
        ylh = iir_sample(hp_coef, xl, hist_xl, hist_hpl);
        yrh = iir_sample(hp_coef, xr, hist_xr, hist_hpr);
        for (int k = 4; k > 0; k--) begin
            hist_xl[k]  = hist_xl[k-1];
            hist_xr[k]  = hist_xr[k-1];
            hist_lpl[k] = hist_lpl[k-1];
            hist_lpr[k] = hist_lpr[k-1];
            hist_hpl[k] = hist_hpl[k-1];
            hist_hpr[k] = hist_hpr[k-1];
        end
        hist_xl[0]  = xl;
        hist_xr[0]  = xr;
        hist_lpl[0] = yll;
        hist_lpr[0] = yrl;
        hist_hpl[0] = ylh;
        hist_hpr[0] = yrh;
        r.surround_left  = clamp_pcm((ylh + 64'sd8388608) >>> 24);
        r.surround_right = clamp_pcm((yrh + 64'sd8388608) >>> 24);
        q = mul_floor(t_s128'(yll) + t_s128'(yrl), t_s128'({1'b0, gain_q12}), 36);
        r.lfe_out = clamp_pcm((q + 1) >>> 1);
        return r;
    endfunction

    // clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // driver: offers the next pending pair, with random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (pcm_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                t_pcm_pair p;
                p = pcm_backlog.pop_front();
                in_ch.valid    <= 1'b1;
                in_ch.left_in  <= p.left;
                in_ch.right_in <= p.right;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // input side monitor: every accepted pair updates the prediction
    always @(posedge clk) begin
        if (rst_n && in_ch.valid && in_ch.ready) begin
            split_due.push_back(crossover_step(in_ch.left_in, in_ch.right_in));
            items_in++;
        end
    end

    // long receiver hold-off, counted on its own
    always @(posedge clk) begin
        if (hold_go && hold_count < HOLD_CYCLES) begin
            hold_count <= hold_count + 1;
        end
    end

    // receiver ready: random stalls, forced low during the hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !(hold_go && hold_count < HOLD_CYCLES)
                            && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // output side monitor: compare against the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            items_out++;
            if (split_due.size() == 0) begin
                $error("result with nothing expected: %0d %0d %0d", out_ch.surround_left,
                       out_ch.surround_right, out_ch.lfe_out);
                fail_count++;
            end else begin
                t_split_out e;
                e = split_due.pop_front();
                if (out_ch.surround_left !== e.surround_left) begin
                    $error("surround_left expected %0d got %0d", e.surround_left,
                           out_ch.surround_left);
                    fail_count++;
                end
                if (out_ch.surround_right !== e.surround_right) begin
                    $error("surround_right expected %0d got %0d", e.surround_right,
                           out_ch.surround_right);
                    fail_count++;
                end
                if (out_ch.lfe_out !== e.lfe_out) begin
                    $error("lfe_out expected %0d got %0d", e.lfe_out, out_ch.lfe_out);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: any handshake restarts the count
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic queue_pair(int l, int r);
        t_pcm_pair p;
        p.left  = scl_pkg::t_smp'(l);
        p.right = scl_pkg::t_smp'(r);
        pcm_backlog.push_back(p);
    endtask

    // waits until everything sent has come back, then lets the block settle
    task automatic drain_all();
        while (pcm_backlog.size() != 0 || in_ch.valid || split_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // gain write over the config channel, to be used only while the block is idle; the task does not check
    task automatic write_gain(logic [15:0] g);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= g;
        do @(posedge clk); while (!cfg_ch.ready);
        gain_q12 = g;
        cfg_ch.valid <= 1'b0;
    endtask

    // directed: full-scale steps, alternating extremes, zeros
    task automatic queue_directed();
        queue_pair(0, 0);
        queue_pair(32767, -32768);
        queue_pair(-32768, 32767);
        for (int i = 0; i < 8; i++) queue_pair(32767, 32767);
        for (int i = 0; i < 6; i++) queue_pair(-32768, -32768);
        for (int i = 0; i < 6; i++) begin
            queue_pair((i % 2) ? 32767 : -32768, (i % 2) ? -32768 : 32767);
        end
        queue_pair(1, -1);
    endtask

    // random program: mostly musical shapes, the rest plain noise
    task automatic queue_program(int count);
        int n, len, kind, amp, per, lvl_l, lvl_r;
        n = 0;
        while (n < count) begin
            kind = $urandom_range(3);
            len  = $urandom_range(4, 30);
            amp  = $urandom_range(32768);
            per  = $urandom_range(1, 12);
            lvl_l = $urandom_range(65535) - 32768;
            lvl_r = $urandom_range(65535) - 32768;
            for (int i = 0; i < len && n < count; i++, n++) begin
                case (kind)
                    0: queue_pair($urandom_range(65535) - 32768, $urandom_range(65535) - 32768);
                    // square wave, both channels, random amplitude and period
                    1: queue_pair(((i / per) % 2) ? amp - 1 : -amp,
                                  ((i / per) % 2) ? -amp : amp - 1);
                    // constant level, pushes the lowpass toward its limits
                    2: queue_pair(lvl_l, lvl_r);
                    // level plus small noise
                    default: queue_pair(lvl_l / 2 + $urandom_range(511) - 256,
                                        lvl_r / 2 + $urandom_range(511) - 256);
                endcase
            end
        end
    endtask

    initial begin
        logic [15:0] phase_gain [5];
        int          phase_send [5];
        int          phase_recv [5];

        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.left_in  = '0;
        in_ch.right_in = '0;
        out_ch.ready   = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fail_count     = 0;
        items_in       = 0;
        items_out      = 0;
        quiet_cycles   = 0;
        hold_go        = 1'b0;
        hold_count     = 0;

        for (int k = 0; k < 6; k++) begin
            hist_xl[k % 5] = 0; hist_xr[k % 5] = 0;
            hist_lpl[k % 5] = 0; hist_lpr[k % 5] = 0;
            hist_hpl[k % 5] = 0; hist_hpr[k % 5] = 0;
        end
        lp_coef  = '{dec_to_q59(64'd5902287323061, 24, 1'b0),
                     dec_to_q59(64'd2951143661531, 23, 1'b0),
                     dec_to_q59(64'd5902287323061, 23, 1'b0),
                     dec_to_q59(64'd5902287323061, 23, 1'b0),
                     dec_to_q59(64'd2951143661531, 23, 1'b0),
                     dec_to_q59(64'd5902287323061, 24, 1'b0)};
        hp_coef  = '{dec_to_q59(64'd981726438035, 12, 1'b0),
                     dec_to_q59(64'd4908632190175, 12, 1'b1),
                     dec_to_q59(64'd981726438035, 11, 1'b0),
                     dec_to_q59(64'd981726438035, 11, 1'b1),
                     dec_to_q59(64'd4908632190175, 12, 1'b0),
                     dec_to_q59(64'd981726438035, 12, 1'b1)};
        den_coef = '{dec_to_q59(64'd1, 0, 1'b0),
                     dec_to_q59(64'd4963115133507, 12, 1'b1),
                     dec_to_q59(64'd9853139865557, 12, 1'b0),
                     dec_to_q59(64'd9780721075822, 12, 1'b1),
                     dec_to_q59(64'd4854483143098, 12, 1'b0),
                     dec_to_q59(64'd963786799137, 12, 1'b1)};
        gain_q12 = 16'd4096;

        // gain and idling per phase: unity, zero, max, random, smallest
        phase_gain = '{16'd4096, 16'd0, 16'hFFFF, 16'($urandom_range(65535)), 16'd1};
        phase_send = '{0, 56, 0, 27, 0};
        phase_recv = '{0, 0, 56, 27, 0};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 5; ph++) begin
            write_gain(phase_gain[ph]);
            send_idle_pct  = phase_send[ph];
            recv_stall_pct = phase_recv[ph];
            if (ph == 0) begin
                queue_directed();
                // sender stops until every result of the directed part is back
                drain_all();
                hold_go <= 1'b1;
            end
            queue_program(345);
            drain_all();
        end

        $display("%0d stereo pairs sent, %0d results checked over five gain settings",
                 items_in, items_out);
        $display("idling: none, sender, receiver, both; one long receiver hold-off");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/scl_pkg.sv
rtl/scl_if.sv
rtl/scl_mul.sv
rtl/stereo_crossover_lfe_split.sv
tb/tb.sv
